// ===== rtl/core/jesc_pkg.sv =====
// Shared types, constants and helper functions for the Julia escape-time pixel unit.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package jesc_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int WORD_W     = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int DIV_W      = ITER_W + COLOR_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int ESC_SHIFT  = 2 * FRAC_BITS + 2;
    localparam bit ESC_BOUNDED = (ESC_SHIFT < PROD_W);
    localparam logic [PROD_W-1:0] ESC_LIMIT =
        ESC_BOUNDED ? (PROD_W'(1) << ESC_SHIFT) : '0;

    localparam logic signed [PROD_W-1:0] WORD_MAX = PROD_W'((64'sd1 <<< (WORD_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] WORD_MIN = -(PROD_W'(64'sd1 <<< (WORD_W - 1)));

    localparam logic signed [WORD_W-1:0] RST_CONST_REAL  = 32'sd0;
    localparam logic signed [WORD_W-1:0] RST_CONST_IMAG  = 32'sd0;
    localparam logic signed [WORD_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] RST_ORIGIN_IMAG = -32'sd536870912;
    localparam logic [STEP_W-1:0]        RST_STEP_REAL   = 31'd894785;
    localparam logic [STEP_W-1:0]        RST_STEP_IMAG   = 31'd894785;
    localparam logic [ITER_W-1:0]        RST_MAX_ITER    = 16'd100;
    localparam logic [COLOR_W-1:0]       RST_BASE_COLOR  = 24'h660000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CONST_REAL  = 3'd0,
        REG_CONST_IMAG  = 3'd1,
        REG_ORIGIN_REAL = 3'd2,
        REG_ORIGIN_IMAG = 3'd3,
        REG_STEP_REAL   = 3'd4,
        REG_STEP_IMAG   = 3'd5,
        REG_MAX_ITER    = 3'd6,
        REG_BASE_COLOR  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] const_real;
        logic signed [WORD_W-1:0] const_imag;
        logic signed [WORD_W-1:0] origin_real;
        logic signed [WORD_W-1:0] origin_imag;
        logic [STEP_W-1:0]        step_real;
        logic [STEP_W-1:0]        step_imag;
        logic [ITER_W-1:0]        max_iterations;
        logic [COLOR_W-1:0]       base_color;
    } cfg_t;

    typedef struct packed {
        logic load_coord;
        logic map;
        logic mult;
        logic update;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic stop;
        logic div_done;
    } status_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WORD_MAX) begin
            r = WORD_MAX[WORD_W-1:0];
        end else if (v < WORD_MIN) begin
            r = WORD_MIN[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mag_word(input logic signed [WORD_W-1:0] a);
        logic [WORD_W-1:0] r;
        r = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jesc_cfg_regs.sv =====
// Configuration register bank for the Julia escape-time pixel unit.
// Depends on jesc_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module jesc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [jesc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [jesc_pkg::WORD_W-1:0]     cfg_wdata,
    output jesc_pkg::cfg_t                      cfg
);

    jesc_pkg::cfg_t cfg_reg;
    jesc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (jesc_pkg::cfg_reg_t'(cfg_addr))
                jesc_pkg::REG_CONST_REAL:  cfg_next.const_real  = $signed(cfg_wdata);
                jesc_pkg::REG_CONST_IMAG:  cfg_next.const_imag  = $signed(cfg_wdata);
                jesc_pkg::REG_ORIGIN_REAL: cfg_next.origin_real = $signed(cfg_wdata);
                jesc_pkg::REG_ORIGIN_IMAG: cfg_next.origin_imag = $signed(cfg_wdata);
                jesc_pkg::REG_STEP_REAL:
                    cfg_next.step_real = cfg_wdata[jesc_pkg::STEP_W-1:0];
                jesc_pkg::REG_STEP_IMAG:
                    cfg_next.step_imag = cfg_wdata[jesc_pkg::STEP_W-1:0];
                jesc_pkg::REG_MAX_ITER:
                    cfg_next.max_iterations = cfg_wdata[jesc_pkg::ITER_W-1:0];
                jesc_pkg::REG_BASE_COLOR:
                    cfg_next.base_color = cfg_wdata[jesc_pkg::COLOR_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.const_real     <= jesc_pkg::RST_CONST_REAL;
            cfg_reg.const_imag     <= jesc_pkg::RST_CONST_IMAG;
            cfg_reg.origin_real    <= jesc_pkg::RST_ORIGIN_REAL;
            cfg_reg.origin_imag    <= jesc_pkg::RST_ORIGIN_IMAG;
            cfg_reg.step_real      <= jesc_pkg::RST_STEP_REAL;
            cfg_reg.step_imag      <= jesc_pkg::RST_STEP_IMAG;
            cfg_reg.max_iterations <= jesc_pkg::RST_MAX_ITER;
            cfg_reg.base_color     <= jesc_pkg::RST_BASE_COLOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/jesc_divider.sv =====
// Restoring radix-2 divider that scales the iteration count into a color, one bit per cycle.
// Depends on jesc_pkg for DIV_W, DIV_CNT_W, ITER_W and COLOR_W.
`timescale 1ns / 1ps
`default_nettype none

module jesc_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [jesc_pkg::DIV_W-1:0]    dividend,
    input  wire logic [jesc_pkg::ITER_W-1:0]   divisor,
    output logic                               done,
    output logic [jesc_pkg::COLOR_W-1:0]       quotient
);

    localparam int REM_W = jesc_pkg::ITER_W + 1;

    logic                           busy_reg;
    logic                           busy_next;
    logic [jesc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [jesc_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [jesc_pkg::DIV_W-1:0]     quo_reg;
    logic [jesc_pkg::DIV_W-1:0]     quo_next;
    logic [REM_W-1:0]               rem_reg;
    logic [REM_W-1:0]               rem_next;
    logic [REM_W-1:0]               trial;
    logic                           fits;

    always_comb begin
        trial     = {rem_reg[REM_W-2:0], quo_reg[jesc_pkg::DIV_W-1]};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = jesc_pkg::DIV_CNT_W'(jesc_pkg::DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - {1'b0, divisor}) : trial;
            quo_next = {quo_reg[jesc_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == jesc_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = busy_reg && (cnt_reg == jesc_pkg::DIV_CNT_W'(1));
    assign quotient = quo_reg[jesc_pkg::COLOR_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/jesc_datapath.sv =====
// Datapath: coordinate mapping, the z = z*z + c iteration, the color divider and result registers.
// Depends on jesc_pkg and instantiates jesc_divider.
`timescale 1ns / 1ps
`default_nettype none

module jesc_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire jesc_pkg::cfg_t                   cfg,
    input  wire jesc_pkg::cmd_t                   cmd,
    output jesc_pkg::status_t                     status,
    input  wire logic [jesc_pkg::COORD_BITS-1:0]  pixel_x,
    input  wire logic [jesc_pkg::COORD_BITS-1:0]  pixel_y,
    output logic [jesc_pkg::COORD_BITS-1:0]       out_x,
    output logic [jesc_pkg::COORD_BITS-1:0]       out_y,
    output logic [jesc_pkg::ITER_W-1:0]           iterations,
    output logic [jesc_pkg::COLOR_W-1:0]          pixel_color
);

    localparam int W  = jesc_pkg::WORD_W;
    localparam int P  = jesc_pkg::PROD_W;
    localparam int F  = jesc_pkg::FRAC_BITS;
    localparam int MW = jesc_pkg::COORD_BITS + jesc_pkg::STEP_W;

    logic [jesc_pkg::COORD_BITS-1:0] x_reg;
    logic [jesc_pkg::COORD_BITS-1:0] y_reg;
    logic signed [W-1:0]             zr_reg;
    logic signed [W-1:0]             zr_next;
    logic signed [W-1:0]             zi_reg;
    logic signed [W-1:0]             zi_next;
    logic [P-1:0]                    rr_reg;
    logic [P-1:0]                    rr_next;
    logic [P-1:0]                    ii_reg;
    logic [P-1:0]                    ii_next;
    logic signed [P-1:0]             ri_reg;
    logic signed [P-1:0]             ri_next;
    logic [jesc_pkg::ITER_W-1:0]     count_reg;
    logic [jesc_pkg::ITER_W-1:0]     count_next;
    logic [jesc_pkg::COORD_BITS-1:0] out_x_reg;
    logic [jesc_pkg::COORD_BITS-1:0] out_y_reg;
    logic [jesc_pkg::ITER_W-1:0]     out_iter_reg;
    logic [jesc_pkg::COLOR_W-1:0]    out_color_reg;

    logic [MW-1:0]              map_re_prod;
    logic [MW-1:0]              map_im_prod;
    logic signed [P-1:0]        map_re_sum;
    logic signed [P-1:0]        map_im_sum;
    logic [W-1:0]               mag_r;
    logic [W-1:0]               mag_i;
    logic [P-1:0]               mag_sum;
    logic                       escape;
    logic signed [P-1:0]        diff;
    logic signed [P-1:0]        upd_re;
    logic signed [P-1:0]        upd_im;
    logic [jesc_pkg::DIV_W-1:0] dividend;
    logic                       div_done;
    logic [jesc_pkg::COLOR_W-1:0] quotient;

    always_comb begin
        map_re_prod = x_reg * cfg.step_real;
        map_im_prod = y_reg * cfg.step_imag;
        map_re_sum  = $signed({{(P-MW){1'b0}}, map_re_prod})
                    + $signed({{(P-W){cfg.origin_real[W-1]}}, cfg.origin_real});
        map_im_sum  = $signed({{(P-MW){1'b0}}, map_im_prod})
                    + $signed({{(P-W){cfg.origin_imag[W-1]}}, cfg.origin_imag});

        mag_r   = jesc_pkg::mag_word(zr_reg);
        mag_i   = jesc_pkg::mag_word(zi_reg);
        rr_next = P'(mag_r) * P'(mag_r);
        ii_next = P'(mag_i) * P'(mag_i);
        ri_next = P'(zr_reg) * P'(zi_reg);

        mag_sum = rr_reg + ii_reg;
        escape  = jesc_pkg::ESC_BOUNDED && (mag_sum >= jesc_pkg::ESC_LIMIT);
        diff    = $signed(rr_reg) - $signed(ii_reg);
        upd_re  = (diff >>> F) + $signed({{(P-W){cfg.const_real[W-1]}}, cfg.const_real});
        upd_im  = (ri_reg >>> (F - 1))
                + $signed({{(P-W){cfg.const_imag[W-1]}}, cfg.const_imag});

        zr_next    = zr_reg;
        zi_next    = zi_reg;
        count_next = count_reg;
        if (cmd.map) begin
            zr_next    = jesc_pkg::sat_word(map_re_sum);
            zi_next    = jesc_pkg::sat_word(map_im_sum);
            count_next = '0;
        end else if (cmd.update) begin
            zr_next    = jesc_pkg::sat_word(upd_re);
            zi_next    = jesc_pkg::sat_word(upd_im);
            count_next = count_reg + 1'b1;
        end

        dividend = jesc_pkg::DIV_W'(count_reg) * jesc_pkg::DIV_W'(cfg.base_color);
    end

    assign status.stop     = (count_reg >= cfg.max_iterations) || escape;
    assign status.div_done = div_done;

    jesc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (cfg.max_iterations),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_coord) begin
            x_reg <= pixel_x;
            y_reg <= pixel_y;
        end
        if (cmd.mult) begin
            rr_reg <= rr_next;
            ii_reg <= ii_next;
            ri_reg <= ri_next;
        end
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        count_reg <= count_next;
        if (cmd.out_load) begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_iter_reg  <= count_reg;
            out_color_reg <= (cfg.max_iterations == '0) ? '0 : quotient;
        end
    end

    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign iterations  = out_iter_reg;
    assign pixel_color = out_color_reg;

endmodule

`default_nettype wire

// ===== rtl/core/jesc_ctrl.sv =====
// Controller state machine that sequences mapping, iteration, division and result hand-off.
// Depends on jesc_pkg for cmd_t and status_t.
`timescale 1ns / 1ps
`default_nettype none

module jesc_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire jesc_pkg::status_t status,
    output jesc_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MAP    = 6'b000010,
        ST_MULT   = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_coord = s_valid;
                if (s_valid) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                cmd.map    = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (status.stop) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end else begin
                    cmd.update = 1'b1;
                    state_next = ST_MULT;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/julia_escape_time_pixel_unit.sv =====
// Julia escape-time pixel unit: the block maps one pixel to z0, iterates z = z*z + c and colors it.
// Depends on jesc_pkg and instantiates jesc_cfg_regs, jesc_ctrl and jesc_datapath.
//
// Usage: the input channel (s_valid/s_ready) takes one beat with a pixel column and row.
// The block maps it to z0 = origin + coordinate * step in Q4.28 and iterates until |z|^2
// reaches 4 or the count reaches max_iterations. The result beat (m_valid/m_ready) carries
// the coordinates, the iteration count n and the color n * base_color / max_iterations.
// From the input beat to result valid the block first maps the coordinate, then spends a
// state per iteration on the three 32x32 squares and products and a state on the escape test
// and the update, then runs the bit-serial color divider and loads the output register.
// One pixel is in flight at a time, the default iteration limit is 100, and the next beat is
// taken in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls the block already takes
// and works on the next pixel and holds its finished result until the register frees up.
// Reset (aresetn low at a clock edge) empties the block and restores the register defaults.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at the next edge; the user
// must make them only while no pixel is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time_pixel_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [jesc_pkg::COORD_BITS-1:0]   s_pixel_x,
    input  wire logic [jesc_pkg::COORD_BITS-1:0]   s_pixel_y,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [jesc_pkg::COORD_BITS-1:0]        m_out_x,
    output logic [jesc_pkg::COORD_BITS-1:0]        m_out_y,
    output logic [jesc_pkg::ITER_W-1:0]            m_iterations,
    output logic [jesc_pkg::COLOR_W-1:0]           m_pixel_color,
    input  wire logic                              cfg_wr_en,
    input  wire logic [jesc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [jesc_pkg::WORD_W-1:0]       cfg_wdata
);

    jesc_pkg::cfg_t    cfg;
    jesc_pkg::cmd_t    cmd;
    jesc_pkg::status_t status;

    jesc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jesc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    jesc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .pixel_x     (s_pixel_x),
        .pixel_y     (s_pixel_y),
        .out_x       (m_out_x),
        .out_y       (m_out_y),
        .iterations  (m_iterations),
        .pixel_color (m_pixel_color)
    );

    // After an input beat the block is busy and cannot take another one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again right after a beat");

    // A new result never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register loaded while still full");

    // The reported count never exceeds the configured limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_iterations <= cfg.max_iterations))
        else $error("iteration count above limit");

    // The divider is started only once the iteration has stopped.
    a_div_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (status.stop && !cmd.update))
        else $error("divider started while iterating");

endmodule

`default_nettype wire

// ===== test/tb_julia_escape_time_pixel_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for julia_escape_time_pixel_unit: pixel beats and register writes in,
// result beats checked field by field against an escape-time predictor kept in a scoreboard.
// Depends on jesc_pkg and the RTL under rtl/core; needs no files or arguments.

module tb_julia_escape_time_pixel_unit;
    import jesc_pkg::*;

    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ITER_W-1:0]     iterations;
        logic [COLOR_W-1:0]    color;
    } pixel_result_t;

    class pixel_scoreboard;
        logic signed [WORD_W-1:0] c_re;
        logic signed [WORD_W-1:0] c_im;
        logic signed [WORD_W-1:0] org_re;
        logic signed [WORD_W-1:0] org_im;
        logic [STEP_W-1:0]        step_re;
        logic [STEP_W-1:0]        step_im;
        logic [ITER_W-1:0]        iter_limit;
        logic [COLOR_W-1:0]       base;
        pixel_result_t            awaited[$];
        int                       errors;
        int                       checked;

        function new();
            c_re       = RST_CONST_REAL;
            c_im       = RST_CONST_IMAG;
            org_re     = RST_ORIGIN_REAL;
            org_im     = RST_ORIGIN_IMAG;
            step_re    = RST_STEP_REAL;
            step_im    = RST_STEP_IMAG;
            iter_limit = RST_MAX_ITER;
            base       = RST_BASE_COLOR;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [WORD_W-1:0] value);
            case (idx)
                REG_CONST_REAL:  c_re = value;
                REG_CONST_IMAG:  c_im = value;
                REG_ORIGIN_REAL: org_re = value;
                REG_ORIGIN_IMAG: org_im = value;
                REG_STEP_REAL:   step_re = value[STEP_W-1:0];
                REG_STEP_IMAG:   step_im = value[STEP_W-1:0];
                REG_MAX_ITER:    iter_limit = value[ITER_W-1:0];
                REG_BASE_COLOR:  base = value[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_HI) return WORD_HI;
            if (v < WORD_LO) return WORD_LO;
            return v;
        endfunction

        function pixel_result_t escape_time(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
            pixel_result_t   r;
            longint          zr;
            longint          zi;
            longint          nr;
            longint          ni;
            longint unsigned rr;
            longint unsigned ii;
            longint          shade;
            int unsigned     count;
            zr = clamp_word(longint'(org_re) + longint'(px) * longint'(step_re));
            zi = clamp_word(longint'(org_im) + longint'(py) * longint'(step_im));
            count = 0;
            while (count < iter_limit) begin
                rr = zr * zr;
                ii = zi * zi;
                if (rr + ii >= ESCAPE_BOUND) break;
                nr = (($signed(rr) - $signed(ii)) >>> FRAC_BITS) + longint'(c_re);
                ni = ((zr * zi) >>> (FRAC_BITS - 1)) + longint'(c_im);
                zr = clamp_word(nr);
                zi = clamp_word(ni);
                count++;
            end
            shade = 0;
            if (iter_limit != 0) begin
                shade = (longint'(count) * longint'(base)) / longint'(iter_limit);
            end
            r.x          = px;
            r.y          = py;
            r.iterations = ITER_W'(count);
            r.color      = COLOR_W'(shade);
            return r;
        endfunction

        function void note_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
            awaited.push_back(escape_time(px, py));
        endfunction

        function void check_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                  logic [ITER_W-1:0] iterations, logic [COLOR_W-1:0] color);
            pixel_result_t e;
            checked++;
            if (awaited.size() == 0) begin
                errors++;
                $error("result beat with no pixel outstanding: x=%0d y=%0d", x, y);
                return;
            end
            e = awaited.pop_front();
            if (x !== e.x) begin
                errors++;
                $error("out_x: expected %0d, got %0d", e.x, x);
            end
            if (y !== e.y) begin
                errors++;
                $error("out_y: expected %0d, got %0d", e.y, y);
            end
            if (iterations !== e.iterations) begin
                errors++;
                $error("iterations: expected %0d, got %0d", e.iterations, iterations);
            end
            if (color !== e.color) begin
                errors++;
                $error("pixel_color: expected 0x%06h, got 0x%06h", e.color, color);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic [COORD_BITS-1:0] s_pixel_x = '0;
    logic [COORD_BITS-1:0] s_pixel_y = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [WORD_W-1:0]     cfg_wdata = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [COORD_BITS-1:0] m_out_x;
    logic [COORD_BITS-1:0] m_out_y;
    logic [ITER_W-1:0]     m_iterations;
    logic [COLOR_W-1:0]    m_pixel_color;

    bit              steady = 1'b0;
    pixel_scoreboard board  = new();

    julia_escape_time_pixel_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_iterations  (m_iterations),
        .m_pixel_color (m_pixel_color),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_reg(idx, value);
    endtask

    task automatic write_all(input logic [WORD_W-1:0] cr, ci, orr, oi, sr, si, lim, shade);
        write_reg(REG_CONST_REAL, cr);
        write_reg(REG_CONST_IMAG, ci);
        write_reg(REG_ORIGIN_REAL, orr);
        write_reg(REG_ORIGIN_IMAG, oi);
        write_reg(REG_STEP_REAL, sr);
        write_reg(REG_STEP_IMAG, si);
        write_reg(REG_MAX_ITER, lim);
        write_reg(REG_BASE_COLOR, shade);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
        while (!steady && $urandom_range(99, 0) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        do @(posedge aclk); while (!s_ready);
        board.note_pixel(px, py);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int n_pixels);
        logic [WORD_W-1:0] cr;
        logic [WORD_W-1:0] ci;
        logic [WORD_W-1:0] orr;
        logic [WORD_W-1:0] oi;
        logic [WORD_W-1:0] sr;
        logic [WORD_W-1:0] si;
        logic [WORD_W-1:0] lim;
        logic [WORD_W-1:0] shade;
        int unsigned       pick;
        pick = $urandom_range(9, 0);
        cr = (pick == 0) ? $urandom : $urandom_range(32'h4000_0000, 0) - 32'h2000_0000;
        ci = (pick == 1) ? $urandom : $urandom_range(32'h4000_0000, 0) - 32'h2000_0000;
        orr = (pick == 2) ? $urandom : $urandom_range(32'h3000_0000, 0) - 32'h2800_0000;
        oi = (pick == 3) ? $urandom : $urandom_range(32'h3000_0000, 0) - 32'h2800_0000;
        pick = $urandom_range(9, 0);
        sr = (pick == 0) ? $urandom :
             (pick < 3) ? $urandom_range(4096, 0) : $urandom_range(32'h0004_0000, 0);
        si = (pick == 1) ? $urandom :
             (pick < 4) ? $urandom_range(4096, 0) : $urandom_range(32'h0004_0000, 0);
        pick = $urandom_range(9, 0);
        lim = (pick == 0) ? 32'd1 : (pick == 1) ? $urandom_range(160, 65) : $urandom_range(64, 2);
        lim[31:16] = $urandom_range(1, 0) ? 16'($urandom) : 16'h0;
        pick = $urandom_range(9, 0);
        shade = (pick == 0) ? 32'h0 : (pick == 1) ? 32'h00FF_FFFF : $urandom;
        write_all(cr, ci, orr, oi, sr, si, lim, shade);
        repeat (n_pixels) begin
            send_pixel(COORD_BITS'($urandom_range(4095, 0)), COORD_BITS'($urandom_range(4095, 0)));
        end
        wait_drained();
    endtask

    initial begin : stimulus
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: corners, the point near z0 = -1 - i and the bounded point near z0 = 0.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd300, 12'd300);
        send_pixel(12'd600, 12'd600);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        wait_drained();

        // A point that never escapes runs into the largest iteration limit.
        write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF, 32'h00FF_FFFF);
        send_pixel(12'd0, 12'd0);
        wait_drained();

        // Saturation of the start value and of both update terms.
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h1333_3333, 32'hECCC_CCCD,
                  32'hFFFF_FFFF, 32'h8000_0001, 32'd1000, 32'hFF12_3456);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_drained();

        // A zero iteration limit gives no iterations and a black pixel.
        write_reg(REG_MAX_ITER, 32'hFFFF_0000);
        cfg_wr_en <= 1'b0;
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1);
        wait_drained();

        for (phase = 0; phase < 12; phase++) begin
            steady = (phase == 4);
            run_random_phase(152);
        end
        steady = 1'b0;

        repeat (300) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.check_pixel(m_out_x, m_out_y, m_iterations, m_pixel_color);
            end
            if (!held && board.checked == 40) begin
                // Long back-pressure while pixels keep coming, so the input must stall.
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (1200) @(posedge aclk);
            end
            m_ready <= steady || ($urandom_range(99, 0) >= 25);
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
